// ===== hw/rtl/dwsp_pkg.sv =====
package dwsp_pkg;

    // Field widths fixed by the interface
    localparam int TGT_W     = 16;
    localparam int ANG_W     = 14;
    localparam int PER_W     = 10;
    localparam int GAIN_W    = 20;
    localparam int DUTY_W    = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    // Default encoder resolution
    localparam int ENC_BITS_DEF = 14;

    // Wheel travel per encoder turn, mm in Q16
    localparam logic [21:0] MM_PER_REV_Q16 = 22'd2350130;

    // Quotient bits produced by the serial divider
    localparam int QUO_W = 17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOWER = 3'd4;

    // Reset values of the configuration registers
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 20'd204800;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 20'd15360;
    localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = 20'd0;
    localparam logic signed [DUTY_W-1:0] DUTY_UPPER_RST = 16'sd255;
    localparam logic signed [DUTY_W-1:0] DUTY_LOWER_RST = -16'sd255;

    // Command from the control unit to a lane
    typedef struct packed {
        logic start;
        logic clear;
    } t_lane_cmd;

    // Result reported by a lane
    typedef struct packed {
        logic                     done;
        logic signed [DUTY_W-1:0] duty;
    } t_lane_res;

    // Loop gains and duty limits
    typedef struct packed {
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        kd;
        logic signed [DUTY_W-1:0] upper;
        logic signed [DUTY_W-1:0] lower;
    } t_gains;

endpackage

// ===== hw/rtl/dwsp_div.sv =====
module dwsp_div import dwsp_pkg::*; #(
    parameter int W = 45
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dvd,
    input  logic [W-1:0] i_dvs,
    output logic         o_done,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dsh;
    logic [QUO_W-1:0] r_quo;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Restoring division, one quotient bit a cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dvd;
            r_dsh <= i_dvs << (QUO_W - 1);
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    // Quotient is complete the cycle after done
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/dwsp_lane.sv =====
module dwsp_lane import dwsp_pkg::*; #(
    parameter int ENCODER_BITS = ENC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_cmd                 i_cmd,
    input  t_gains                    i_gains,
    input  logic signed [TGT_W-1:0]   i_target,
    input  logic signed [ENCODER_BITS:0] i_delta,
    input  logic [PER_W-1:0]          i_period,
    output t_lane_res                 o_res
);

    localparam int DLT_W = ENCODER_BITS + 1;
    localparam int DIV_W = (ENCODER_BITS + 31 > 44) ? ENCODER_BITS + 31 : 44;
    localparam int M_W   = 44;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_PREP = 12'b000000000010,
        S_DIV1 = 12'b000000000100,
        S_ERR  = 12'b000000001000,
        S_MUL1 = 12'b000000010000,
        S_MUL2 = 12'b000000100000,
        S_MUL3 = 12'b000001000000,
        S_SUM  = 12'b000010000000,
        S_NORM = 12'b000100000000,
        S_SATC = 12'b001000000000,
        S_DIV2 = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // Loop state
    logic signed [31:0] r_integ;
    logic signed [17:0] r_last;

    // Working registers
    logic signed [TGT_W-1:0] r_tgt;
    logic signed [DLT_W-1:0] r_delta;
    logic [PER_W-1:0]        r_p;
    logic [19:0]             r_pk;
    logic signed [17:0]      r_err;
    logic signed [18:0]      r_diff;
    logic signed [27:0]      r_a;
    logic [29:0]             r_kip;
    logic signed [59:0]      r_kdd;
    logic signed [58:0]      r_t1;
    logic signed [62:0]      r_t2;
    logic signed [63:0]      r_num;
    logic [M_W-1:0]          r_m;
    logic                    r_sgn;
    logic                    r_sat;
    logic                    r_done;
    logic signed [DUTY_W-1:0] r_duty;

    // Divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dvd, div_dvs;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;

    logic [ENCODER_BITS-1:0] mag_d;
    logic [ENCODER_BITS+21:0] prod1;
    logic [DIV_W-1:0]        n1, d1;
    logic signed [17:0]      spd, err;
    logic signed [18:0]      diff;
    logic signed [28:0]      a_full;
    logic signed [39:0]      kdd_full;
    logic signed [32:0]      isum;
    logic signed [31:0]      isat;
    logic signed [48:0]      t1_full;
    logic signed [62:0]      t2_full;
    logic [63:0]             mag_n;
    logic [63:0]             m_full;
    logic                    sat;
    logic signed [17:0]      q18, u, up, lo;

    // Speed division operands: |delta|*travel + half divisor, over p<<(4+EB)
    always_comb begin
        mag_d = r_delta[DLT_W-1] ? ENCODER_BITS'(-r_delta) : ENCODER_BITS'(r_delta);
        prod1 = mag_d * MM_PER_REV_Q16;
        n1    = DIV_W'(prod1) + (DIV_W'(r_p) << (ENCODER_BITS + 3));
        d1    = DIV_W'(r_p) << (ENCODER_BITS + 4);
    end

    always_comb begin
        div_start = (r_state == S_PREP) || ((r_state == S_SATC) && !sat);
        div_dvd   = (r_state == S_PREP) ? n1 : DIV_W'(r_m);
        div_dvs   = (r_state == S_PREP) ? d1 : DIV_W'(r_pk);
    end

    dwsp_div #(.W(DIV_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Error and derivative difference
    always_comb begin
        spd  = r_delta[DLT_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        err  = 18'(r_tgt) - spd;
        diff = 19'(err) - 19'(r_last);
    end

    // Products and integral saturation
    always_comb begin
        a_full   = r_err * $signed({1'b0, r_p});
        kdd_full = $signed({1'b0, i_gains.kd}) * r_diff;
        isum     = 33'(r_integ) + 33'(r_a);
        isat     = (isum[32] != isum[31]) ?
                   (isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : isum[31:0];
        t1_full  = $signed({1'b0, i_gains.kp}) * r_a;
        t2_full  = $signed({1'b0, r_kip}) * r_integ;
    end

    // Round to nearest on the 2^20 part of the divisor, then saturate check
    always_comb begin
        mag_n  = r_num[63] ? 64'(-r_num) : 64'(r_num);
        m_full = (mag_n + (64'(r_pk) << 19)) >> 20;
        sat    = r_m >= (M_W'(r_pk) << 17);
    end

    // Sign, clamp to upper then lower
    always_comb begin
        q18 = r_sat ? 18'sh10000 : $signed({1'b0, div_quo});
        u   = r_sgn ? -q18 : q18;
        up  = 18'(i_gains.upper);
        lo  = 18'(i_gains.lower);
        if (u > up) begin
            u = up;
        end
        if (u < lo) begin
            u = lo;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd.start) n_state = S_PREP;
            S_PREP: n_state = S_DIV1;
            S_DIV1: if (div_done) n_state = S_ERR;
            S_ERR:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_SUM;
            S_SUM:  n_state = S_NORM;
            S_NORM: n_state = S_SATC;
            S_SATC: n_state = sat ? S_FIN : S_DIV2;
            S_DIV2: if (div_done) n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_integ <= '0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
            if (i_cmd.clear) begin
                r_integ <= '0;
                r_last  <= '0;
            end else begin
                if (r_state == S_ERR) begin
                    r_last <= err;
                end
                if (r_state == S_MUL2) begin
                    r_integ <= isat;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_cmd.start) begin
            r_tgt   <= i_target;
            r_delta <= i_delta;
            r_p     <= i_period;
            r_pk    <= 20'(i_period) * 20'd1000;
        end
        if (r_state == S_ERR) begin
            r_err  <= err;
            r_diff <= diff;
        end
        if (r_state == S_MUL1) begin
            r_a   <= a_full[27:0];
            r_kdd <= 60'(kdd_full);
            r_kip <= 30'(i_gains.ki) * 30'(r_p);
        end
        if (r_state == S_MUL2) begin
            r_t1 <= 59'(t1_full);
        end
        if (r_state == S_MUL3) begin
            r_t2  <= t2_full;
            r_t1  <= r_t1 * 59'sd1000;
            r_kdd <= r_kdd * 60'sd1000000;
        end
        if (r_state == S_SUM) begin
            r_num <= 64'(r_t1) + 64'(r_t2) + 64'(r_kdd);
        end
        if (r_state == S_NORM) begin
            r_m   <= m_full[M_W-1:0];
            r_sgn <= r_num[63];
        end
        if (r_state == S_SATC) begin
            r_sat <= sat;
        end
        if (r_state == S_FIN) begin
            r_duty <= u[DUTY_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.duty = r_duty;

endmodule

// ===== hw/rtl/dual_wheel_speed_pid.sv =====
// Flow: a normal tick runs both lanes in ST_RUN, then waits in ST_HOLD until the output
// register loads and raises o_valid; if both targets are zero, on the first tick or at
// zero period, it goes straight to ST_HOLD. Input is taken only in ST_IDLE. Each lane
// runs the 17-step serial divider for speed, then for duty unless the duty saturates.
// Reset: synchronous, active low; restores the default gains and clamps, clears the
// integrators, last errors, captured angles and the angle-valid flag.
module dual_wheel_speed_pid import dwsp_pkg::*; #(
    parameter int ENCODER_BITS = ENC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [TGT_W-1:0]   i_target_right,
    input  logic signed [TGT_W-1:0]   i_target_left,
    input  logic [ANG_W-1:0]          i_angle_right,
    input  logic [ANG_W-1:0]          i_angle_left,
    input  logic [PER_W-1:0]          i_period_ms,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [DUTY_W-1:0]  o_duty_right,
    output logic signed [DUTY_W-1:0]  o_duty_left,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int EB = ENCODER_BITS;
    localparam logic [EB-1:0] HALF = EB'(1) << (EB - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_top_state;

    t_top_state r_state;

    t_gains         r_gains;
    logic [EB-1:0]  r_ang_r, r_ang_l;
    logic           r_ang_valid;
    logic           r_got_r, r_got_l;
    logic signed [DUTY_W-1:0] r_res_r, r_res_l;
    logic           r_ovalid;
    logic signed [DUTY_W-1:0] r_odr, r_odl;

    logic           accept, both_zero, out_load, got_r, got_l;
    logic [EB-1:0]  a_r, a_l, dd_r, dd_l;
    logic signed [EB:0] dlt_r, dlt_l;
    t_lane_cmd      cmd;
    t_lane_res      res_r, res_l;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == ST_IDLE);
    assign both_zero = (i_target_right == '0) && (i_target_left == '0);

    // Encoder deltas, wrapped to -(2^(EB-1)-1) .. 2^(EB-1); right wheel negated
    always_comb begin
        a_r   = EB'(i_angle_right);
        a_l   = EB'(i_angle_left);
        dd_r  = a_r - r_ang_r;
        dd_l  = a_l - r_ang_l;
        dlt_r = -$signed({(dd_r > HALF), dd_r});
        dlt_l = $signed({(dd_l > HALF), dd_l});
    end

    // Lane commands
    always_comb begin
        cmd.clear = accept && both_zero;
        cmd.start = accept && !both_zero && r_ang_valid && (i_period_ms != '0);
    end

    dwsp_lane #(.ENCODER_BITS(EB)) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_gains  (r_gains),
        .i_target (i_target_right),
        .i_delta  (dlt_r),
        .i_period (i_period_ms),
        .o_res    (res_r)
    );

    dwsp_lane #(.ENCODER_BITS(EB)) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_gains  (r_gains),
        .i_target (i_target_left),
        .i_delta  (dlt_l),
        .i_period (i_period_ms),
        .o_res    (res_l)
    );

    assign got_r    = r_got_r || res_r.done;
    assign got_l    = r_got_l || res_l.done;
    assign out_load = (r_state == ST_HOLD) && (!r_ovalid || i_ready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp    <= PROP_GAIN_RST;
            r_gains.ki    <= INTEG_GAIN_RST;
            r_gains.kd    <= DERIV_GAIN_RST;
            r_gains.upper <= DUTY_UPPER_RST;
            r_gains.lower <= DUTY_LOWER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROP_GAIN:  r_gains.kp    <= i_cfg_data;
                CFG_INTEG_GAIN: r_gains.ki    <= i_cfg_data;
                CFG_DERIV_GAIN: r_gains.kd    <= i_cfg_data;
                CFG_DUTY_UPPER: r_gains.upper <= i_cfg_data[DUTY_W-1:0];
                CFG_DUTY_LOWER: r_gains.lower <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick control, angle capture and lane merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ang_r     <= '0;
            r_ang_l     <= '0;
            r_ang_valid <= 1'b0;
            r_got_r     <= 1'b0;
            r_got_l     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (!both_zero) begin
                            r_ang_r     <= a_r;
                            r_ang_l     <= a_l;
                            r_ang_valid <= 1'b1;
                        end
                        r_state <= cmd.start ? ST_RUN : ST_HOLD;
                    end
                end
                ST_RUN: begin
                    if (got_r && got_l) begin
                        r_got_r <= 1'b0;
                        r_got_l <= 1'b0;
                        r_state <= ST_HOLD;
                    end else begin
                        r_got_r <= got_r;
                        r_got_l <= got_l;
                    end
                end
                ST_HOLD: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_r <= '0;
            r_res_l <= '0;
        end else if (r_state == ST_RUN) begin
            if (res_r.done) begin
                r_res_r <= res_r.duty;
            end
            if (res_l.done) begin
                r_res_l <= res_l.duty;
            end
        end
        if (out_load) begin
            r_odr <= r_res_r;
            r_odl <= r_res_l;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_duty_right = r_odr;
    assign o_duty_left  = r_odl;

    // Lanes only report while a tick is in flight
    a_lane_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_r.done || res_l.done) |-> (r_state == ST_RUN))
        else $error("lane result outside a running tick");

    // One tick at a time: a transfer closes the input side
    a_single_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("input taken while a tick is in progress");

    // Once captured, the angles stay valid until reset
    a_angle_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ang_valid |=> r_ang_valid)
        else $error("angle-valid flag dropped");

endmodule
